// ===== src/ecf_pkg.sv =====
// Shared constants, mode codes and constant tables for the epoch-to-calendar block.
`default_nettype none

package ecf_pkg;

  localparam int TIME_BITS_DEF = 43;
  localparam int OUT_BITS      = 22;
  localparam int ZONE_BITS     = 5;
  localparam int ZMS_BITS      = 28;   // zone offset in ms, signed

  localparam longint MS_SECOND    = 64'd1000;
  localparam longint MS_MINUTE    = 64'd60000;
  localparam longint MS_HOUR      = 64'd3600000;
  localparam longint MS_DAY       = 64'd86400000;
  localparam longint MS_WEEK      = 64'd604800000;
  localparam longint MS_YEAR      = 64'd365 * MS_DAY;
  localparam longint MS_LEAP_YEAR = 64'd366 * MS_DAY;
  localparam longint MS_FOUR_DAYS = 64'd4 * MS_DAY;

  localparam logic signed [22:0] MS_HOUR_S = 23'sd3600000;

  localparam int YEAR_BASE = 1970;
  localparam int C100_BASE = 70;    // 1970 mod 100
  localparam int C400_BASE = 370;   // 1970 mod 400

  localparam logic [3:0] MODE_YEAR    = 4'd0;
  localparam logic [3:0] MODE_MONTH   = 4'd1;
  localparam logic [3:0] MODE_DAY     = 4'd2;
  localparam logic [3:0] MODE_HOUR    = 4'd3;
  localparam logic [3:0] MODE_MINUTE  = 4'd4;
  localparam logic [3:0] MODE_SECOND  = 4'd5;
  localparam logic [3:0] MODE_MILLI   = 4'd6;
  localparam logic [3:0] MODE_WEEKS   = 4'd7;
  localparam logic [3:0] MODE_DAYS    = 4'd8;
  localparam logic [3:0] MODE_HOURS   = 4'd9;
  localparam logic [3:0] MODE_WEEKDAY = 4'd10;

  localparam logic [3:0] MONTH_LAST = 4'd11;

  // Month length in ms; February follows the leap flag.
  function automatic longint ecf_month_ms(input logic [3:0] m, input logic leap);
    longint days;
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: days = 64'd31;
      4'd1:    days = leap ? 64'd29 : 64'd28;
      default: days = 64'd30;
    endcase
    return days * MS_DAY;
  endfunction

  // Divisor for the first or second division pass of a mode.
  function automatic longint ecf_div_ms(input logic [3:0] mode, input logic second);
    longint d;
    if (second) begin
      case (mode)
        MODE_HOUR:   d = MS_HOUR;
        MODE_MINUTE: d = MS_MINUTE;
        MODE_SECOND: d = MS_SECOND;
        default:     d = MS_DAY;
      endcase
    end else begin
      case (mode)
        MODE_HOUR, MODE_DAYS:     d = MS_DAY;
        MODE_MINUTE, MODE_HOURS:  d = MS_HOUR;
        MODE_SECOND:              d = MS_MINUTE;
        MODE_MILLI:               d = MS_SECOND;
        MODE_WEEKS, MODE_WEEKDAY: d = MS_WEEK;
        default:                  d = MS_DAY;
      endcase
    end
    return d;
  endfunction

  // Modes that divide the first remainder again.
  function automatic logic ecf_two_pass(input logic [3:0] mode);
    logic r;
    case (mode)
      MODE_HOUR, MODE_MINUTE, MODE_SECOND, MODE_WEEKDAY: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/epoch_ms_to_calendar_field.sv =====
// Top level: epoch milliseconds to one calendar field, iterative sequencer.
//
//  channel  signals                              direction  payload
//  -------  -----------------------------------  ---------  ------------------------------
//  in       in_valid / in_ready                  in         epoch_millis, mode
//  out      out_valid / out_ready                out        field_value, before_epoch
//  cfg      cfg_valid / cfg_ready                in         zone_offset_hours
//
//  One item at a time. Set-up states S_PREP and S_SETUP, then per mode:
//    year/month/day : walk the years one by one, then the months up to December,
//                     then the day division (day of month only)
//    hour/min/sec/weekday : two division passes; ms/weeks/days/hours : one pass
//  S_DONE then loads the output register. Every step goes through the one
//  shared subtractor.
//  Reset (rst, synchronous) clears the sequencer, output valid and the zone.
//  No memory, so no clearing pass. A finished result waits in the output
//  register; the next item is taken meanwhile, and holds in its last state
//  only if its own result is ready before the previous one is taken.
`default_nettype none

module epoch_ms_to_calendar_field
  import ecf_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TIME_BITS-1:0] epoch_millis,
  input  logic [3:0]           mode,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_BITS-1:0]  field_value,
  output logic                 before_epoch,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ZONE_BITS-1:0] zone_offset_hours
);

  // Working width: local time may pass 2^TIME_BITS by the zone and the four-day shift.
  localparam int     W         = TIME_BITS + 1;
  localparam int     CNT_BITS  = $clog2(W);
  localparam longint MaxYears  = (64'd1 << TIME_BITS) / MS_YEAR + 64'd1;
  localparam int     YEAR_BITS = $clog2(YEAR_BASE + MaxYears + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PREP  = 8'b0000_0010,
    S_SETUP = 8'b0000_0100,
    S_YEAR  = 8'b0000_1000,
    S_MONTH = 8'b0001_0000,
    S_DIV1  = 8'b0010_0000,
    S_DIV2  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  logic signed [ZMS_BITS-1:0] zone_ms;
  logic [W-1:0]           utc;
  logic [3:0]             mode_r;
  logic                   flag;
  logic [W-1:0]           acc;      // remaining time, or division remainder
  logic [W-1:0]           num;      // dividend shifting out, quotient shifting in
  logic [CNT_BITS-1:0]    cnt;
  logic [YEAR_BITS-1:0]   year;
  logic [6:0]             c100;
  logic [8:0]             c400;
  logic [3:0]             month;

  logic signed [W:0]      local_s;
  logic                   leap;
  logic [W-1:0]           sub_a;
  logic [W-1:0]           sub_b;
  logic [W-1:0]           diff;
  logic                   ge;
  logic [W-1:0]           div_cur;
  logic [W-1:0]           step_acc;
  logic [W-1:0]           step_num;
  logic [W-1:0]           num_inc;
  logic [W-1:0]           setup_base;
  logic [W-1:0]           setup_ofs;
  logic [OUT_BITS-1:0]    value;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign local_s = $signed({1'b0, utc}) + (W+1)'(zone_ms);

  // Gregorian rule from the running mod-4/100/400 counts
  assign leap = ((year[1:0] == 2'b00) && (c100 != 7'd0)) || (c400 == 9'd0);

  assign div_cur = W'(ecf_div_ms(mode_r, state == S_DIV2));

  always_comb begin
    sub_a = acc;
    sub_b = div_cur;
    case (state)
      S_YEAR:  sub_b = leap ? W'(MS_LEAP_YEAR) : W'(MS_YEAR);
      S_MONTH: sub_b = W'(ecf_month_ms(month, leap));
      S_DIV1, S_DIV2: sub_a = {acc[W-2:0], num[W-1]};
      default: sub_a = acc;
    endcase
  end

  ecf_sub_unit #(.WIDTH(W)) u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (diff),
    .ge   (ge)
  );

  // restoring division step
  assign step_acc = ge ? diff : sub_a;
  assign step_num = {num[W-2:0], ge};
  assign num_inc  = num + W'(1);

  // weeks and weekday count from the Sunday four days before the epoch
  assign setup_base = ((mode_r == MODE_WEEKS) || (mode_r == MODE_DAYS) ||
                       (mode_r == MODE_HOURS)) ? utc : acc;
  assign setup_ofs  = ((mode_r == MODE_WEEKS) || (mode_r == MODE_WEEKDAY)) ?
                      W'(MS_FOUR_DAYS) : '0;

  always_comb begin
    case (mode_r)
      MODE_YEAR:                value = OUT_BITS'(year);
      MODE_MONTH:               value = OUT_BITS'(month);
      MODE_DAY, MODE_WEEKDAY:   value = num_inc[OUT_BITS-1:0];
      MODE_HOUR, MODE_MINUTE, MODE_SECOND,
      MODE_WEEKS, MODE_DAYS, MODE_HOURS:
                                value = num[OUT_BITS-1:0];
      MODE_MILLI:               value = acc[OUT_BITS-1:0];
      default:                  value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      zone_ms   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        zone_ms <= $signed(zone_offset_hours) * MS_HOUR_S;
      end
      // the finishing state reloads the output register itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            utc    <= {1'b0, epoch_millis};
            mode_r <= mode;
            state  <= S_PREP;
          end
        end
        S_PREP: begin
          // clamp negative local time to zero
          flag  <= local_s[W];
          acc   <= local_s[W] ? '0 : local_s[W-1:0];
          state <= S_SETUP;
        end
        S_SETUP: begin
          year  <= YEAR_BITS'(YEAR_BASE);
          c100  <= 7'(C100_BASE);
          c400  <= 9'(C400_BASE);
          month <= '0;
          cnt   <= CNT_BITS'(W - 1);
          case (mode_r)
            MODE_YEAR, MODE_MONTH, MODE_DAY: state <= S_YEAR;
            MODE_HOUR, MODE_MINUTE, MODE_SECOND, MODE_MILLI,
            MODE_WEEKS, MODE_DAYS, MODE_HOURS, MODE_WEEKDAY: begin
              num   <= setup_base + setup_ofs;
              acc   <= '0;
              state <= S_DIV1;
            end
            default: state <= S_DONE;
          endcase
        end
        S_YEAR: begin
          if (ge) begin
            acc  <= diff;
            year <= year + YEAR_BITS'(1);
            c100 <= (c100 == 7'd99)  ? 7'd0 : c100 + 7'd1;
            c400 <= (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
          end else begin
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if ((month == MONTH_LAST) || !ge) begin
            if (mode_r == MODE_DAY) begin
              num   <= acc;
              acc   <= '0;
              cnt   <= CNT_BITS'(W - 1);
              state <= S_DIV2;
            end else begin
              state <= S_DONE;
            end
          end else begin
            acc   <= diff;
            month <= month + 4'd1;
          end
        end
        S_DIV1: begin
          if ((cnt == '0) && ecf_two_pass(mode_r)) begin
            // remainder becomes the next dividend
            num   <= step_acc;
            acc   <= '0;
            cnt   <= CNT_BITS'(W - 1);
            state <= S_DIV2;
          end else begin
            acc <= step_acc;
            num <= step_num;
            if (cnt == '0) begin
              state <= S_DONE;
            end else begin
              cnt <= cnt - CNT_BITS'(1);
            end
          end
        end
        S_DIV2: begin
          acc <= step_acc;
          num <= step_num;
          if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt - CNT_BITS'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            field_value  <= value;
            before_epoch <= flag;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // remainder stays below the divisor through every division step
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV1 || state == S_DIV2) |-> (acc < div_cur))
    else $error("division remainder not below divisor");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MONTH) |-> (month <= MONTH_LAST))
    else $error("month walk past December");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again while an item is in progress");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the finishing state");

endmodule

`default_nettype wire

// ===== src/ecf_sub_unit.sv =====
// Shared subtract-and-compare unit used by every walk and division step.
`default_nettype none

module ecf_sub_unit
  import ecf_pkg::*;
#(
  parameter int WIDTH = TIME_BITS_DEF + 1
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output logic             ge
);

  logic [WIDTH:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[WIDTH-1:0];
  assign ge   = ~full[WIDTH];   // no borrow: a >= b

endmodule

`default_nettype wire

// ===== verif/epoch_ms_to_calendar_field_tb.sv =====
// Self-checking testbench for the epoch-milliseconds-to-calendar-field block.
`timescale 1ns / 1ps

module epoch_ms_to_calendar_field_tb
  import ecf_pkg::*;
();

  // Mode codes beyond the package's list: all of them must give 0.
  localparam logic [3:0] MODE_FIRST_UNUSED = 4'd11;
  localparam logic [3:0] MODE_LAST_CODE    = 4'd15;

  localparam longint TIME_MAX  = (64'd1 << TIME_BITS_DEF) - 1;
  localparam int     LAST_YEAR = 2248;          // year reached just below TIME_MAX

  // Dates that sit on calendar corners (UTC, ms since the epoch)
  localparam longint LEAP_DAY_2000 = 64'd951_782_400_000;     // 2000-02-29, leap century
  localparam longint MARCH_2100    = 64'd4_107_542_400_000;   // 2100-03-01, non-leap century
  localparam longint DEC31_1972    = 64'd94_608_000_000;      // last day of a leap year

  localparam int LONG_HOLD_CYCLES = 3000;   // far longer than one conversion
  localparam int END_SETTLE       = 400;    // longer than the worst conversion
  localparam int WATCHDOG_NS      = 20_000_000;

  typedef struct packed {
    logic [TIME_BITS_DEF-1:0] ms;
    logic [3:0]               md;
  } epoch_req_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic                neg;
  } field_due_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT signals. Everything driven from time zero.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [TIME_BITS_DEF-1:0]    epoch_millis = '0;
  logic [3:0]                  mode = MODE_YEAR;

  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [OUT_BITS-1:0]         field_value;
  logic                        before_epoch;

  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic signed [ZONE_BITS-1:0] zone_offset_hours = '0;

  always #4 clk = ~clk;

  epoch_ms_to_calendar_field u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .epoch_millis      (epoch_millis),
    .mode              (mode),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .field_value       (field_value),
    .before_epoch      (before_epoch),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .zone_offset_hours (zone_offset_hours)
  );

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  epoch_req_t epoch_req_q[$];     // items waiting to be offered
  field_due_t field_due_q[$];     // predicted results, oldest first

  logic signed [ZONE_BITS-1:0] zone_model = '0;   // mirror of the zone register

  int send_idle_pct = 19;
  int recv_idle_pct = 50;
  int hold_asked    = 0;          // bumped by the sequence to ask for a long stall
  int hold_served   = 0;
  int hold_left     = 0;

  int items_taken  = 0;
  int results_seen = 0;
  int clamped_seen = 0;
  int zones_used   = 1;
  int fail_count   = 0;

  // ---------------------------------------------------------------------------
  // Calendar arithmetic for the predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_leap(input int yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic longint days_in_year(input int yr);
    return is_leap(yr) ? 64'd366 : 64'd365;
  endfunction

  // mo is 0-based
  function automatic longint month_days(input int yr, input int mo);
    longint d;
    case (mo)
      1:             d = is_leap(yr) ? 64'd29 : 64'd28;
      3, 5, 8, 10:   d = 64'd30;
      default:       d = 64'd31;
    endcase
    return d;
  endfunction

  // Predicts the one result of an item. Local time is UTC plus the zone; if
  // that goes negative it is clamped to zero and flagged. Weeks/days/hours
  // since the epoch stay on UTC and ignore the clamp.
  function automatic field_due_t calendar_field_of(input logic [TIME_BITS_DEF-1:0] utc_ms,
                                                   input logic [3:0] code,
                                                   input logic signed [ZONE_BITS-1:0] zone);
    field_due_t r;
    longint     utc;
    longint     wall;
    longint     rest;
    longint     v;
    int         yr;
    int         mo;
    utc  = longint'(utc_ms);
    wall = utc + longint'(zone) * MS_HOUR;
    r.neg = (wall < 0);
    if (r.neg) wall = 0;

    // walk whole years, then months of the year reached
    yr   = YEAR_BASE;
    rest = wall;
    while (rest >= days_in_year(yr) * MS_DAY) begin
      rest -= days_in_year(yr) * MS_DAY;
      yr++;
    end
    mo = 0;
    while (mo < 11 && rest >= month_days(yr, mo) * MS_DAY) begin
      rest -= month_days(yr, mo) * MS_DAY;
      mo++;
    end

    case (code)
      MODE_YEAR:    v = yr;
      MODE_MONTH:   v = mo;
      MODE_DAY:     v = rest / MS_DAY + 1;
      MODE_HOUR:    v = (wall % MS_DAY) / MS_HOUR;
      MODE_MINUTE:  v = (wall % MS_HOUR) / MS_MINUTE;
      MODE_SECOND:  v = (wall % MS_MINUTE) / MS_SECOND;
      MODE_MILLI:   v = wall % MS_SECOND;
      MODE_WEEKS:   v = (utc + MS_FOUR_DAYS) / MS_WEEK;
      MODE_DAYS:    v = utc / MS_DAY;
      MODE_HOURS:   v = utc / MS_HOUR;
      MODE_WEEKDAY: v = ((wall + MS_FOUR_DAYS) % MS_WEEK) / MS_DAY + 1;
      default:      v = 0;
    endcase
    r.value = v[OUT_BITS-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random items: half spread over the whole range, the rest aimed at the
  // clamp region near zero, at local midnights (+/- 1 ms) in a month's first
  // 28 days and at the top of the time range. One in eight uses an unused mode code.
  // ---------------------------------------------------------------------------
  function automatic epoch_req_t random_request(input logic signed [ZONE_BITS-1:0] zone);
    epoch_req_t q;
    longint     t;
    longint     day;
    int         yr;
    int         mo;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4:
        t = (longint'($urandom_range(0, 2047)) << 32) | longint'($urandom);
      5, 6:
        t = longint'($urandom_range(0, 200_000_000));
      7, 8: begin
        yr  = $urandom_range(YEAR_BASE, LAST_YEAR);
        mo  = $urandom_range(0, 11);
        day = 0;
        for (int y = YEAR_BASE; y < yr; y++) day += days_in_year(y);
        for (int m = 0; m < mo; m++) day += month_days(yr, m);
        if ($urandom_range(0, 1) != 0) day += $urandom_range(0, 27);
        // local midnight, then one ms either side
        t = day * MS_DAY - longint'(zone) * MS_HOUR + longint'($urandom_range(0, 2)) - 1;
      end
      default:
        t = TIME_MAX - longint'($urandom_range(0, 200_000_000));
    endcase
    if (t < 0) t = 0;
    if (t > TIME_MAX) t = TIME_MAX;
    q.ms = t[TIME_BITS_DEF-1:0];
    if ($urandom_range(0, 7) == 0)
      q.md = 4'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_CODE));
    else
      q.md = 4'($urandom_range(MODE_YEAR, MODE_WEEKDAY));
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: offers the head of epoch_req_q, holds the payload until it
  // is taken, and predicts the result at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    epoch_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        field_due_q.insert(field_due_q.size(),
                           calendar_field_of(epoch_millis, mode, zone_model));
        items_taken++;
      end
      // slot is free once nothing is on offer or the current item was taken
      if (!in_valid || in_ready) begin
        if (epoch_req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = epoch_req_q.pop_front();
          epoch_millis <= nxt.ms;
          mode         <= nxt.md;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: checks every taken result against the oldest prediction
  // and drives out_ready, including the long stall the sequence asks for.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    field_due_t due;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (before_epoch) clamped_seen++;
        if (field_due_q.size() == 0) begin
          $error("unexpected result: field_value=%0d before_epoch=%0b",
                 field_value, before_epoch);
          fail_count++;
        end else begin
          due = field_due_q.pop_front();
          if (field_value !== due.value) begin
            $error("field_value: expected %0d, got %0d", due.value, field_value);
            fail_count++;
          end
          if (before_epoch !== due.neg) begin
            $error("before_epoch: expected %0b, got %0b", due.neg, before_epoch);
            fail_count++;
          end
        end
      end

      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_served != hold_asked) begin
        hold_served++;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  // Zone register write; only called with nothing in flight.
  task automatic write_zone(input logic signed [ZONE_BITS-1:0] z);
    @(posedge clk);
    cfg_valid         <= 1'b1;
    zone_offset_hours <= z;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    zone_model  = z;
    zones_used++;
  endtask

  task automatic queue_request(input longint t, input logic [3:0] code);
    epoch_req_t q;
    q.ms = t[TIME_BITS_DEF-1:0];
    q.md = code;
    epoch_req_q.insert(epoch_req_q.size(), q);
  endtask

  // Queues random items on the falling edge (clear of the driver), optionally
  // asks for the long receiver stall, then waits until every result is in.
  task automatic fill_and_drain(input int n_random, input int send_pct, input int recv_pct,
                                input bit long_hold);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_random) epoch_req_q.insert(epoch_req_q.size(), random_request(zone_model));
    if (long_hold) hold_asked++;
    while (epoch_req_q.size() != 0 || in_valid || field_due_q.size() != 0)
      @(posedge clk);
  endtask

  initial begin : sequence_main
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Zone at its reset value of 0. Every mode code at the epoch, then the
    // top of the time range and a few calendar corners.
    @(negedge clk);
    for (int k = 0; k <= MODE_LAST_CODE; k++) queue_request(0, 4'(k));
    queue_request(TIME_MAX, MODE_YEAR);
    queue_request(TIME_MAX, MODE_HOURS);
    queue_request(LEAP_DAY_2000, MODE_DAY);
    queue_request(MARCH_2100 - 1, MODE_DAY);
    queue_request(DEC31_1972, MODE_MONTH);
    fill_and_drain(0, 19, 50, 1'b0);

    // Most negative zone: clamp just below zero, exactly zero, UTC modes
    // unaffected by the clamp, flag still given with an unused mode.
    write_zone(-5'sd16);
    @(negedge clk);
    queue_request(0, MODE_HOUR);
    queue_request(0, MODE_WEEKS);
    queue_request(16 * MS_HOUR - 1, MODE_LAST_CODE);
    queue_request(16 * MS_HOUR, MODE_HOUR);
    fill_and_drain(125, 19, 50, 1'b0);

    // Swap idling; the long stall lets the block fill and push back
    write_zone(5'sd15);
    fill_and_drain(125, 50, 19, 1'b1);

    write_zone(-5'sd12);
    fill_and_drain(125, 50, 19, 1'b0);

    // No idling from here on
    write_zone(5'sd14);
    fill_and_drain(125, 0, 0, 1'b0);

    repeat (5) begin
      write_zone(5'($urandom_range(0, 31)));
      fill_and_drain(25, 0, 0, 1'b0);
    end

    repeat (END_SETTLE) @(posedge clk);

    $display("covered %0d items (all 16 mode codes) under %0d zone settings",
             items_taken, zones_used);
    $display("%0d results checked, %0d of them clamped before the epoch",
             results_seen, clamped_seen);
    if (fail_count == 0 && field_due_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, many times the slowest legal run
  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== epoch_ms_to_calendar_field.f =====
src/ecf_pkg.sv
src/ecf_sub_unit.sv
src/epoch_ms_to_calendar_field.sv
verif/epoch_ms_to_calendar_field_tb.sv
